@@ design/hrlp_pkg.sv @@
// Shared types and constants for the HTTP request line parser.
package hrlp_pkg;

    // Default parameter values.
    localparam int METHOD_CAP_DEF = 16;
    localparam int PATH_CAP_DEF   = 128;
    localparam int MAX_LENGTH_DEF = 65535;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Byte codes that the parser looks for.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    // Result kinds.
    localparam logic [1:0] KIND_METHOD  = 2'd0;
    localparam logic [1:0] KIND_PATH    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Verdict codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NEED_MORE = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    // One emitted method or path character.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [6:0] index;
        logic [7:0] value;
    } char_item_t;

    // The final verdict of a buffer.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic        line_ok;
        logic [3:0]  method_length;
        logic [6:0]  path_length;
        logic [15:0] blank_offset;
    } verdict_t;

    // Everything one input byte causes, in delivery order.
    typedef struct packed {
        char_item_t ch0;
        char_item_t ch1;
        verdict_t   verdict;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ design/hrlp_front.sv @@
// Front part: per-byte request line parsing and blank line search.
module hrlp_front #(
    parameter int METHOD_CAP = hrlp_pkg::METHOD_CAP_DEF,
    parameter int PATH_CAP   = hrlp_pkg::PATH_CAP_DEF,
    parameter int MAX_LENGTH = hrlp_pkg::MAX_LENGTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            byte_value,
    input  logic                  last_byte,
    input  hrlp_pkg::queue_status_t q_status,
    output logic                  push,
    output hrlp_pkg::entry_t      push_entry
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int EXT_W = (CNT_W + 1 > 16) ? CNT_W + 1 : 16;
    localparam int METHOD_LIMIT_I = (METHOD_CAP - 1 > 15) ? 15 : METHOD_CAP - 1;
    localparam int PATH_LIMIT_I = (PATH_CAP - 1 > 127) ? 127 : PATH_CAP - 1;
    localparam logic [3:0] METHOD_LIMIT = 4'(METHOD_LIMIT_I);
    localparam logic [6:0] PATH_LIMIT = 7'(PATH_LIMIT_I);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_LENGTH);

    typedef enum logic [3:0] {
        PH_METHOD  = 4'b0001,
        PH_PATH    = 4'b0010,
        PH_REST    = 4'b0100,
        PH_HEADERS = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [3:0]           method_count;
        logic [6:0]           path_count;
        logic                 line_bad;
        hrlp_pkg::char_item_t item;
    } line_res_t;

    // Handles one character of the first line, never the CR of the line end.
    function automatic line_res_t line_char(
        input phase_t     ph,
        input logic [3:0] mc,
        input logic [6:0] pc,
        input logic       bad,
        input logic [7:0] c
    );
        line_res_t r;
        r.phase        = ph;
        r.method_count = mc;
        r.path_count   = pc;
        r.line_bad     = bad;
        r.item         = '0;
        unique case (ph)
            PH_METHOD:
            begin
                if (c == hrlp_pkg::CHAR_SP)
                begin
                    if (mc == 4'd0)
                    begin
                        r.line_bad = 1'b1;
                    end
                    r.phase = PH_PATH;
                end
                else if (mc < METHOD_LIMIT)
                begin
                    r.item.valid    = 1'b1;
                    r.item.kind     = hrlp_pkg::KIND_METHOD;
                    r.item.index    = {3'b000, mc};
                    r.item.value    = c;
                    r.method_count  = mc + 4'd1;
                end
            end
            PH_PATH:
            begin
                if (c == hrlp_pkg::CHAR_SP)
                begin
                    if (pc == 7'd0)
                    begin
                        r.line_bad = 1'b1;
                    end
                    r.phase = PH_REST;
                end
                else if (pc < PATH_LIMIT)
                begin
                    r.item.valid = 1'b1;
                    r.item.kind  = hrlp_pkg::KIND_PATH;
                    r.item.index = pc;
                    r.item.value = c;
                    r.path_count = pc + 7'd1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [3:0]       method_count_reg, method_count_next;
    logic [6:0]       path_count_reg, path_count_next;
    logic             held_cr_reg, held_cr_next;
    logic [1:0]       blank_match_reg, blank_match_next;
    logic             blank_found_reg, blank_found_next;
    logic [15:0]      blank_end_reg, blank_end_next;
    logic             line_bad_reg, line_bad_next;
    logic             overlong_reg, overlong_next;

    logic             accept;
    logic [EXT_W-1:0] pos_plus_one;
    line_res_t        res0;
    line_res_t        res1;
    hrlp_pkg::entry_t entry;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign pos_plus_one = EXT_W'(byte_count_reg) + EXT_W'(1);

    // Next state and the results of the byte on the input.
    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        method_count_next = method_count_reg;
        path_count_next   = path_count_reg;
        held_cr_next      = held_cr_reg;
        blank_match_next  = blank_match_reg;
        blank_found_next  = blank_found_reg;
        blank_end_next    = blank_end_reg;
        line_bad_next     = line_bad_reg;
        overlong_next     = overlong_reg;
        entry             = '0;
        res0              = '0;
        res1              = '0;

        // Byte count saturates; past the limit the buffer is overlong.
        if (byte_count_reg >= COUNT_MAX)
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
        end

        // Search for the first CR LF CR LF anywhere in the buffer.
        if (!blank_found_reg)
        begin
            case (blank_match_reg)
                2'd0: blank_match_next = (byte_value == hrlp_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                2'd1: blank_match_next = (byte_value == hrlp_pkg::CHAR_LF) ? 2'd2 :
                                         (byte_value == hrlp_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                2'd2: blank_match_next = (byte_value == hrlp_pkg::CHAR_CR) ? 2'd3 : 2'd0;
                default:
                begin
                    if (byte_value == hrlp_pkg::CHAR_LF)
                    begin
                        blank_found_next = 1'b1;
                        blank_end_next   = pos_plus_one[15:0];
                        blank_match_next = 2'd0;
                    end
                    else
                    begin
                        blank_match_next = (byte_value == hrlp_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end

        // First line: a CR is held until it is known whether an LF follows.
        if (phase_reg != PH_HEADERS)
        begin
            if (held_cr_reg && byte_value == hrlp_pkg::CHAR_LF)
            begin
                held_cr_next = 1'b0;
                if (phase_reg == PH_METHOD || phase_reg == PH_PATH)
                begin
                    line_bad_next = 1'b1;
                end
                phase_next = PH_HEADERS;
            end
            else
            begin
                if (held_cr_reg)
                begin
                    held_cr_next      = 1'b0;
                    res0              = line_char(phase_next, method_count_next,
                                                  path_count_next, line_bad_next,
                                                  hrlp_pkg::CHAR_CR);
                    phase_next        = res0.phase;
                    method_count_next = res0.method_count;
                    path_count_next   = res0.path_count;
                    line_bad_next     = res0.line_bad;
                    entry.ch0         = res0.item;
                end
                if (byte_value == hrlp_pkg::CHAR_CR)
                begin
                    held_cr_next = 1'b1;
                end
                else
                begin
                    res1              = line_char(phase_next, method_count_next,
                                                  path_count_next, line_bad_next,
                                                  byte_value);
                    phase_next        = res1.phase;
                    method_count_next = res1.method_count;
                    path_count_next   = res1.path_count;
                    line_bad_next     = res1.line_bad;
                    entry.ch1         = res1.item;
                end
            end
        end

        // Verdict on the last byte, then back to the reset state.
        if (last_byte)
        begin
            entry.verdict.valid = 1'b1;
            if (overlong_next)
            begin
                entry.verdict.status = hrlp_pkg::STATUS_ERROR;
            end
            else if (phase_next != PH_HEADERS)
            begin
                entry.verdict.status = hrlp_pkg::STATUS_NEED_MORE;
            end
            else if (line_bad_next)
            begin
                entry.verdict.status = hrlp_pkg::STATUS_ERROR;
            end
            else
            begin
                entry.verdict.line_ok       = 1'b1;
                entry.verdict.method_length = method_count_next;
                entry.verdict.path_length   = path_count_next;
                if (blank_found_next)
                begin
                    entry.verdict.status       = hrlp_pkg::STATUS_OK;
                    entry.verdict.blank_offset = blank_end_next;
                end
                else
                begin
                    entry.verdict.status = hrlp_pkg::STATUS_NEED_MORE;
                end
            end
            phase_next        = PH_METHOD;
            byte_count_next   = '0;
            method_count_next = '0;
            path_count_next   = '0;
            held_cr_next      = 1'b0;
            blank_match_next  = 2'd0;
            blank_found_next  = 1'b0;
            blank_end_next    = '0;
            line_bad_next     = 1'b0;
            overlong_next     = 1'b0;
        end
    end

    assign push       = accept && (entry.ch0.valid || entry.ch1.valid || entry.verdict.valid);
    assign push_entry = entry;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_METHOD;
            byte_count_reg   <= '0;
            method_count_reg <= '0;
            path_count_reg   <= '0;
            held_cr_reg      <= 1'b0;
            blank_match_reg  <= 2'd0;
            blank_found_reg  <= 1'b0;
            blank_end_reg    <= '0;
            line_bad_reg     <= 1'b0;
            overlong_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            method_count_reg <= method_count_next;
            path_count_reg   <= path_count_next;
            held_cr_reg      <= held_cr_next;
            blank_match_reg  <= blank_match_next;
            blank_found_reg  <= blank_found_next;
            blank_end_reg    <= blank_end_next;
            line_bad_reg     <= line_bad_next;
            overlong_reg     <= overlong_next;
        end
    end

endmodule

@@ design/hrlp_queue.sv @@
// Short queue of per-byte result bundles between the front and the back.
module hrlp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hrlp_pkg::entry_t        push_entry,
    input  logic                    pop,
    output hrlp_pkg::entry_t        head_entry,
    output hrlp_pkg::queue_status_t q_status
);

    localparam int PTR_W = $clog2(hrlp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hrlp_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hrlp_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hrlp_pkg::QUEUE_DEPTH);

    hrlp_pkg::entry_t mem_reg [hrlp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign head_entry     = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/hrlp_back.sv @@
// Back part: unpacks queued bundles into single results behind an output register.
module hrlp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hrlp_pkg::entry_t        head_entry,
    input  hrlp_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [6:0]              char_index,
    output logic [7:0]              char_value,
    output logic [1:0]              status,
    output logic                    line_ok,
    output logic [3:0]              method_length,
    output logic [6:0]              path_length,
    output logic [15:0]             blank_offset,
    output logic                    last
);

    logic [2:0]  done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  pending;
    logic [2:0]  sel;
    logic        load;
    logic        final_item;
    logic [1:0]  kind_next;
    logic [6:0]  char_index_next;
    logic [7:0]  char_value_next;
    logic [1:0]  status_next;
    logic        line_ok_next;
    logic [3:0]  method_length_next;
    logic [6:0]  path_length_next;
    logic [15:0] blank_offset_next;
    logic        last_next;
    logic [1:0]  kind_reg;
    logic [6:0]  char_index_reg;
    logic [7:0]  char_value_reg;
    logic [1:0]  status_reg;
    logic        line_ok_reg;
    logic [3:0]  method_length_reg;
    logic [6:0]  path_length_reg;
    logic [15:0] blank_offset_reg;
    logic        last_reg;

    // Pick the first result of the head bundle that is not yet sent.
    assign pending = {head_entry.verdict.valid, head_entry.ch1.valid,
                      head_entry.ch0.valid} & ~done_reg;
    assign sel = pending[0] ? 3'b001 : pending[1] ? 3'b010 : pending[2] ? 3'b100 : 3'b000;
    assign final_item = ((pending & ~sel) == 3'b000);
    assign load = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop  = load && final_item;

    // Payload of the selected result.
    always_comb
    begin
        kind_next          = hrlp_pkg::KIND_VERDICT;
        char_index_next    = '0;
        char_value_next    = '0;
        status_next        = head_entry.verdict.status;
        line_ok_next       = head_entry.verdict.line_ok;
        method_length_next = head_entry.verdict.method_length;
        path_length_next   = head_entry.verdict.path_length;
        blank_offset_next  = head_entry.verdict.blank_offset;
        last_next          = 1'b1;
        if (sel[0] || sel[1])
        begin
            kind_next          = sel[0] ? head_entry.ch0.kind : head_entry.ch1.kind;
            char_index_next    = sel[0] ? head_entry.ch0.index : head_entry.ch1.index;
            char_value_next    = sel[0] ? head_entry.ch0.value : head_entry.ch1.value;
            status_next        = hrlp_pkg::STATUS_OK;
            line_ok_next       = 1'b0;
            method_length_next = '0;
            path_length_next   = '0;
            blank_offset_next  = '0;
            last_next          = 1'b0;
        end
    end

    // Progress through the head bundle and the output valid flag.
    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            done_next      = final_item ? 3'b000 : (done_reg | sel);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg          <= kind_next;
            char_index_reg    <= char_index_next;
            char_value_reg    <= char_value_next;
            status_reg        <= status_next;
            line_ok_reg       <= line_ok_next;
            method_length_reg <= method_length_next;
            path_length_reg   <= path_length_next;
            blank_offset_reg  <= blank_offset_next;
            last_reg          <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign char_index    = char_index_reg;
    assign char_value    = char_value_reg;
    assign status        = status_reg;
    assign line_ok       = line_ok_reg;
    assign method_length = method_length_reg;
    assign path_length   = path_length_reg;
    assign blank_offset  = blank_offset_reg;
    assign last          = last_reg;

endmodule

@@ design/http_request_line_parser_unit.sv @@
// Top level of the HTTP request line parser: front, queue and back.
//
// The block takes one request byte per transfer and, at the byte flagged last, gives a verdict
// with the method and path lengths and the offset past the first blank line, then starts over
// for the next buffer. Method and path characters come out as they are parsed, each with its
// index. The front parses one byte per cycle while the queue is not full; a byte can cause up
// to three results (a held CR, the byte itself, the verdict), and the back sends one result per
// cycle while the output is not stalled, so the input sustains one byte per cycle whenever each
// byte yields at most one result and the output does not stall, and slows to the output rate of
// one result per cycle otherwise. A four-entry queue between front and back absorbs short bursts.
// A byte's results go into the queue at its transfer, then through the back's output register.
module http_request_line_parser_unit #(
    parameter int METHOD_CAP = hrlp_pkg::METHOD_CAP_DEF,
    parameter int PATH_CAP   = hrlp_pkg::PATH_CAP_DEF,
    parameter int MAX_LENGTH = hrlp_pkg::MAX_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [6:0]  char_index,
    output logic [7:0]  char_value,
    output logic [1:0]  status,
    output logic        line_ok,
    output logic [3:0]  method_length,
    output logic [6:0]  path_length,
    output logic [15:0] blank_offset,
    output logic        last
);

    hrlp_pkg::queue_status_t q_status;
    hrlp_pkg::entry_t        push_entry;
    hrlp_pkg::entry_t        head_entry;
    logic                    push;
    logic                    pop;

    // Byte parser.
    hrlp_front #(
        .METHOD_CAP (METHOD_CAP),
        .PATH_CAP   (PATH_CAP),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    hrlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // Result sequencer.
    hrlp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_index    (char_index),
        .char_value    (char_value),
        .status        (status),
        .line_ok       (line_ok),
        .method_length (method_length),
        .path_length   (path_length),
        .blank_offset  (blank_offset),
        .last          (last)
    );

`ifndef SYNTH
    // The queue is never written while full, nor read while empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

    // Only a verdict carries the last mark, and an ok verdict has a valid line.
    a_last_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == hrlp_pkg::KIND_VERDICT)))
        else $error("last mark on a character result");

    a_ok_has_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == hrlp_pkg::KIND_VERDICT && status == hrlp_pkg::STATUS_OK)
        |-> line_ok)
        else $error("ok verdict without a valid request line");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP request line parser, with its own byte-level predictor.
module tb;

    // Limits that the parser applies with its default parameters.
    localparam int METHOD_LIMIT = (hrlp_pkg::METHOD_CAP_DEF - 1 > 15) ? 15 :
                                  hrlp_pkg::METHOD_CAP_DEF - 1;
    localparam int PATH_LIMIT   = (hrlp_pkg::PATH_CAP_DEF - 1 > 127) ? 127 :
                                  hrlp_pkg::PATH_CAP_DEF - 1;
    localparam int LENGTH_LIMIT = hrlp_pkg::MAX_LENGTH_DEF;
    localparam int DRAIN_CYCLES = 20;

    // Where the predictor stands within the first line.
    typedef enum logic [1:0] {
        FIELD_METHOD,
        FIELD_PATH,
        FIELD_REST,
        FIELD_HEADERS
    } line_field_t;

    // Progress of the search for the blank line.
    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_CR,
        MATCH_CRLF,
        MATCH_CRLFCR
    } blank_match_t;

    // One expected result of the parser.
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  index;
        logic [7:0]  value;
        logic [1:0]  status;
        logic        line_ok;
        logic [3:0]  method_length;
        logic [6:0]  path_length;
        logic [15:0] blank_offset;
        logic        last;
    } parse_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [6:0]  char_index;
    logic [7:0]  char_value;
    logic [1:0]  status;
    logic        line_ok;
    logic [3:0]  method_length;
    logic [6:0]  path_length;
    logic [15:0] blank_offset;
    logic        last;

    http_request_line_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_value    (byte_value),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_index    (char_index),
        .char_value    (char_value),
        .status        (status),
        .line_ok       (line_ok),
        .method_length (method_length),
        .path_length   (path_length),
        .blank_offset  (blank_offset),
        .last          (last)
    );

    // Results the predictor has worked out and the parser has not yet delivered.
    parse_result_t expected_results[$];

    // Bytes of the request buffer being assembled.
    logic [7:0] req_bytes[$];

    // Predictor state.
    line_field_t  field;
    blank_match_t blank_state;
    int           seen_bytes;
    int           meth_n;
    int           path_n;
    int           blank_at;
    logic         cr_held;
    logic         blank_done;
    logic         line_bad;
    logic         too_long;

    // Pacing controls shared by the sender, the receiver and the tests.
    logic pace_on = 1'b1;
    logic stall_on = 1'b1;
    int   hold_left = 0;
    int   burst_left = 0;

    // Run statistics.
    int errors = 0;
    int buffers_sent = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int verdicts_by_status[4] = '{0, 0, 0, 0};

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #(8 * 100000);
        $display("tb: FAIL");
        $finish;
    end

    // Predictor: return to the state of a fresh buffer.
    task automatic clear_predictor();
        field       = FIELD_METHOD;
        blank_state = MATCH_NONE;
        seen_bytes  = 0;
        meth_n      = 0;
        path_n      = 0;
        blank_at    = 0;
        cr_held     = 1'b0;
        blank_done  = 1'b0;
        line_bad    = 1'b0;
        too_long    = 1'b0;
    endtask

    // Predictor: queue one emitted method or path character.
    task automatic push_char(input logic [1:0] k, input int idx, input logic [7:0] c);
        parse_result_t r;
        r = '0;
        r.kind  = k;
        r.index = idx[6:0];
        r.value = c;
        expected_results.push_back(r);
    endtask

    // Predictor: one character of the first line, never the CR of the line end.
    task automatic take_line_char(input logic [7:0] c);
        if (field == FIELD_METHOD)
        begin
            if (c == hrlp_pkg::CHAR_SP)
            begin
                if (meth_n == 0)
                    line_bad = 1'b1;
                field = FIELD_PATH;
            end
            else if (meth_n < METHOD_LIMIT)
            begin
                push_char(hrlp_pkg::KIND_METHOD, meth_n, c);
                meth_n++;
            end
        end
        else if (field == FIELD_PATH)
        begin
            if (c == hrlp_pkg::CHAR_SP)
            begin
                if (path_n == 0)
                    line_bad = 1'b1;
                field = FIELD_REST;
            end
            else if (path_n < PATH_LIMIT)
            begin
                push_char(hrlp_pkg::KIND_PATH, path_n, c);
                path_n++;
            end
        end
    endtask

    // Predictor: everything one transferred byte causes.
    task automatic predict_byte(input logic [7:0] c, input logic is_last);
        int            pos;
        parse_result_t v;
        pos = seen_bytes;
        if (seen_bytes >= LENGTH_LIMIT)
            too_long = 1'b1;
        else
            seen_bytes++;

        // Search for CR LF CR LF anywhere in the buffer.
        if (!blank_done)
        begin
            case (blank_state)
                MATCH_NONE:
                    blank_state = (c == hrlp_pkg::CHAR_CR) ? MATCH_CR : MATCH_NONE;
                MATCH_CR:
                    blank_state = (c == hrlp_pkg::CHAR_LF) ? MATCH_CRLF :
                                  (c == hrlp_pkg::CHAR_CR) ? MATCH_CR : MATCH_NONE;
                MATCH_CRLF:
                    blank_state = (c == hrlp_pkg::CHAR_CR) ? MATCH_CRLFCR : MATCH_NONE;
                default:
                begin
                    if (c == hrlp_pkg::CHAR_LF)
                    begin
                        blank_done  = 1'b1;
                        blank_at    = pos + 1;
                        blank_state = MATCH_NONE;
                    end
                    else
                    begin
                        blank_state = (c == hrlp_pkg::CHAR_CR) ? MATCH_CR : MATCH_NONE;
                    end
                end
            endcase
        end

        // First line, with a CR held back until the next byte tells whether the line ends.
        if (field != FIELD_HEADERS)
        begin
            if (cr_held && c == hrlp_pkg::CHAR_LF)
            begin
                cr_held = 1'b0;
                if (field == FIELD_METHOD || field == FIELD_PATH)
                    line_bad = 1'b1;
                field = FIELD_HEADERS;
            end
            else
            begin
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    take_line_char(hrlp_pkg::CHAR_CR);
                end
                if (c == hrlp_pkg::CHAR_CR)
                    cr_held = 1'b1;
                else
                    take_line_char(c);
            end
        end

        // Verdict at the end of the buffer.
        if (is_last)
        begin
            v = '0;
            v.kind = hrlp_pkg::KIND_VERDICT;
            v.last = 1'b1;
            if (too_long)
                v.status = hrlp_pkg::STATUS_ERROR;
            else if (field != FIELD_HEADERS)
                v.status = hrlp_pkg::STATUS_NEED_MORE;
            else if (line_bad)
                v.status = hrlp_pkg::STATUS_ERROR;
            else
            begin
                v.line_ok       = 1'b1;
                v.method_length = meth_n[3:0];
                v.path_length   = path_n[6:0];
                if (blank_done)
                begin
                    v.status       = hrlp_pkg::STATUS_OK;
                    v.blank_offset = blank_at[15:0];
                end
                else
                begin
                    v.status = hrlp_pkg::STATUS_NEED_MORE;
                end
            end
            expected_results.push_back(v);
            clear_predictor();
        end
    endtask

    // Offer one byte, in bursts with random gaps, and predict once it is transferred.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = 0;
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(0, 5);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            in_valid   <= 1'b0;
            byte_value <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, is_last);
        bytes_sent++;
    endtask

    // Append text to the buffer being assembled.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    // Send the assembled buffer, flagging its final byte as last.
    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        buffers_sent++;
        req_bytes.delete();
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_request();
    endtask

    // A method, path or header character: mostly printable, sometimes any byte or a lone CR.
    function automatic logic [7:0] field_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 3)
            return hrlp_pkg::CHAR_CR;
        b = (r < 75) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
        if (b == hrlp_pkg::CHAR_SP || b == hrlp_pkg::CHAR_CR)
            b = 8'h2F;
        return b;
    endfunction

    // Receiver: stalls on randomly chosen patterns, each kept for a random span, or holds off on request.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!stall_on)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Compare one field of a result.
    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("field %s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Check each transferred result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expectation: kind %0d", kind);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("char_index", 32'(want.index), 32'(char_index));
                check_field("char_value", 32'(want.value), 32'(char_value));
                check_field("status", 32'(want.status), 32'(status));
                check_field("line_ok", 32'(want.line_ok), 32'(line_ok));
                check_field("method_length", 32'(want.method_length), 32'(method_length));
                check_field("path_length", 32'(want.path_length), 32'(path_length));
                check_field("blank_offset", 32'(want.blank_offset), 32'(blank_offset));
                check_field("last", 32'(want.last), 32'(last));
                if (want.kind == hrlp_pkg::KIND_VERDICT)
                    verdicts_by_status[want.status]++;
            end
        end
    end

    // Complete requests, including the extreme character values 0x00 and 0xFF.
    task automatic test_well_formed();
        req_bytes.push_back(8'hFF);
        req_bytes.push_back(8'h00);
        add_text(" /");
        req_bytes.push_back(8'hFF);
        req_bytes.push_back(8'h00);
        add_text(" X\015\012\015\012");
        send_request();
        // The blank line search must resynchronize after CR LF CR CR.
        send_text("P /q H\015\012\015\015\012\015\012");
    endtask

    // Buffers that end before the line end or before the blank line.
    task automatic test_need_more();
        send_text("G /a");
        send_text("G / H\015\012");
        send_text("G");
    endtask

    // Empty method, empty path, and line ends before the first or the second space.
    task automatic test_bad_lines();
        send_text(" / H\015\012\015\012");
        send_text("G  H\015\012");
        send_text("G\015\012");
        send_text("G /x\015\012");
    endtask

    // Lone CRs inside fields, CR CR, and a CR held back at the final byte.
    task automatic test_carriage_returns();
        send_text("G\015T / x\015\012\015\012");
        send_text("G /a\015\015b c\015\012");
        send_text("G /a\015");
        // A lone CR, the byte after it and the verdict, all from one byte.
        send_text("G /a\015b");
    endtask

    // A method longer than its capacity.
    task automatic test_truncation();
        for (int i = 0; i < 17; i++)
            req_bytes.push_back(8'h41 + 8'(i));
        add_text(" /x H\015\012");
        send_request();
    endtask

    // The receiver holds off while the sender keeps offering path characters.
    task automatic test_back_pressure();
        pace_on = 1'b0;
        hold_left = 30;
        add_text("GET /");
        for (int i = 0; i < 10; i++)
            req_bytes.push_back(8'h30 + 8'(i));
        add_text(" H\015\012");
        send_request();
        pace_on = 1'b1;
    endtask

    // Mostly well-formed requests with random content, plus noise and cut-off buffers.
    task automatic test_random_requests();
        int random_total;
        int n;
        int r;
        random_total = 0;
        while (random_total < 10)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                n = $urandom_range(1, 30);
                repeat (n)
                begin
                    r = $urandom_range(0, 7);
                    req_bytes.push_back(r == 0 ? hrlp_pkg::CHAR_CR :
                                        r == 1 ? hrlp_pkg::CHAR_LF :
                                        r == 2 ? hrlp_pkg::CHAR_SP :
                                        8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 8);
                repeat (n) req_bytes.push_back(field_char());
                if ($urandom_range(0, 15) != 0)
                    req_bytes.push_back(hrlp_pkg::CHAR_SP);
                n = $urandom_range(0, 12);
                repeat (n) req_bytes.push_back(field_char());
                add_text(" HTTP/1.1");
                if ($urandom_range(0, 9) != 0)
                    add_text("\015\012");
                repeat ($urandom_range(0, 3))
                begin
                    repeat ($urandom_range(1, 6)) req_bytes.push_back(field_char());
                    add_text("\015\012");
                end
                if ($urandom_range(0, 4) != 0)
                    add_text("\015\012");
                repeat ($urandom_range(0, 4)) req_bytes.push_back(8'($urandom_range(0, 255)));
                // Some buffers are cut off at a random point.
                if ($urandom_range(0, 7) == 0)
                begin
                    n = $urandom_range(1, req_bytes.size());
                    while (req_bytes.size() > n)
                        void'(req_bytes.pop_back());
                end
            end
            random_total += req_bytes.size();
            send_request();
        end
    endtask

    // Main sequence.
    initial
    begin
        clear_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_need_more();
        test_bad_lines();
        test_carriage_returns();
        test_truncation();
        test_back_pressure();
        test_random_requests();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d buffers, %0d bytes, %0d results checked", buffers_sent,
                 bytes_sent, results_seen);
        $display("summary: verdicts ok %0d, need more %0d, error %0d",
                 verdicts_by_status[hrlp_pkg::STATUS_OK],
                 verdicts_by_status[hrlp_pkg::STATUS_NEED_MORE],
                 verdicts_by_status[hrlp_pkg::STATUS_ERROR]);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
